// ===== src/uart_register_interrupt_model_assert.svh =====
// Assertion macros used by the checker file.
`ifndef UART_REGISTER_INTERRUPT_MODEL_ASSERT_SVH
`define UART_REGISTER_INTERRUPT_MODEL_ASSERT_SVH

// Same-cycle implication, dropped while rst is high.
`define URIM_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("urim check failed: same-cycle implication");

// Next-cycle implication, dropped while rst is high.
`define URIM_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("urim check failed: next-cycle implication");

`endif

// ===== src/urim_pkg.sv =====
package urim_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] opcode_type;
   typedef logic [2:0] offset_type;
   typedef logic [2:0] ident_type;

   // Request kinds
   localparam opcode_type OP_READ    = 2'd0;
   localparam opcode_type OP_WRITE   = 2'd1;
   localparam opcode_type OP_RECEIVE = 2'd2;
   localparam opcode_type OP_UNUSED  = 2'd3;

   // Register offsets
   localparam offset_type OFS_DATA    = 3'd0;
   localparam offset_type OFS_IER     = 3'd1;
   localparam offset_type OFS_IIR_FCR = 3'd2;
   localparam offset_type OFS_LCR     = 3'd3;
   localparam offset_type OFS_MCR     = 3'd4;
   localparam offset_type OFS_LSR     = 3'd5;
   localparam offset_type OFS_MSR     = 3'd6;
   localparam offset_type OFS_SCRATCH = 3'd7;

   // Interrupt identification codes
   localparam ident_type IIR_NONE     = 3'd1;
   localparam ident_type IIR_TX_EMPTY = 3'd2;
   localparam ident_type IIR_RX_DATA  = 3'd4;

   // Bit positions
   localparam int LSR_DR_BIT   = 0;
   localparam int LSR_THRE_BIT = 5;
   localparam int IER_RXDA_BIT = 0;
   localparam int IER_THRE_BIT = 1;
   localparam int LCR_DLAB_BIT = 7;

   // Reset values
   localparam byte_type LSR_RESET = 8'h60;
   localparam byte_type DLL_RESET = 8'h45;
   localparam byte_type DLM_RESET = 8'h01;

   typedef struct packed {
      opcode_type opcode;
      offset_type reg_offset;
      byte_type   write_byte;
      byte_type   rx_byte;
   } req_type;

   typedef struct packed {
      byte_type  read_byte;
      logic      tx_valid;
      byte_type  tx_byte;
      logic      irq_pulse;
      ident_type irq_ident;
   } rsp_type;

endpackage

// ===== src/urim_if.sv =====
interface urim_req_if import urim_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   offset_type reg_offset;
   byte_type   write_byte;
   byte_type   rx_byte;

   modport source (output valid, opcode, reg_offset, write_byte, rx_byte, input ready);
   modport sink   (input valid, opcode, reg_offset, write_byte, rx_byte, output ready);
endinterface

interface urim_rsp_if import urim_pkg::*; ();
   logic      valid;
   logic      ready;
   byte_type  read_byte;
   logic      tx_valid;
   byte_type  tx_byte;
   logic      irq_pulse;
   ident_type irq_ident;

   modport source (output valid, read_byte, tx_valid, tx_byte, irq_pulse, irq_ident,
                   input ready);
   modport sink   (input valid, read_byte, tx_valid, tx_byte, irq_pulse, irq_ident,
                   output ready);
endinterface

// ===== src/urim_regfile.sv =====
module urim_regfile import urim_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   output rsp_type rsp
);

   byte_type  ier_ff, ier_in;
   byte_type  fcr_ff, fcr_in;
   byte_type  lcr_ff, lcr_in;
   byte_type  mcr_ff, mcr_in;
   byte_type  lsr_ff, lsr_in;
   byte_type  msr_ff, msr_in;
   byte_type  scr_ff, scr_in;
   byte_type  dll_ff, dll_in;
   byte_type  dlm_ff, dlm_in;
   ident_type iir_ff, iir_in;
   byte_type  rxh_ff, rxh_in;
   logic      irq_active_ff, irq_active_in;
   logic      tx_reported_ff, tx_reported_in;

   logic      dlab;
   logic      tx_rep_pre;
   logic      rx_irq;
   logic      tx_irq;
   logic      want;

   assign dlab = lcr_ff[LCR_DLAB_BIT];

   // Apply one request to the register file, then re-evaluate the interrupt
   always_comb begin
      ier_in         = ier_ff;
      fcr_in         = fcr_ff;
      lcr_in         = lcr_ff;
      mcr_in         = mcr_ff;
      lsr_in         = lsr_ff;
      msr_in         = msr_ff;
      scr_in         = scr_ff;
      dll_in         = dll_ff;
      dlm_in         = dlm_ff;
      rxh_in         = rxh_ff;
      tx_rep_pre     = tx_reported_ff;
      rsp            = '0;

      unique case (req.opcode)
         OP_READ: begin
            unique case (req.reg_offset)
               OFS_DATA: begin
                  if (dlab) begin
                     rsp.read_byte = dll_ff;
                  end else begin
                     rsp.read_byte        = rxh_ff;
                     lsr_in[LSR_DR_BIT]   = 1'b0;
                  end
               end
               OFS_IER:     rsp.read_byte = dlab ? dlm_ff : ier_ff;
               OFS_IIR_FCR: rsp.read_byte = byte_type'(iir_ff);
               OFS_LCR:     rsp.read_byte = lcr_ff;
               OFS_MCR:     rsp.read_byte = mcr_ff;
               OFS_LSR:     rsp.read_byte = lsr_ff;
               OFS_MSR:     rsp.read_byte = msr_ff;
               OFS_SCRATCH: rsp.read_byte = scr_ff;
            endcase
         end
         OP_WRITE: begin
            unique case (req.reg_offset)
               OFS_DATA: begin
                  if (dlab) begin
                     dll_in = req.write_byte;
                  end else begin
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = req.write_byte;
                     tx_rep_pre   = 1'b0;
                  end
               end
               OFS_IER: begin
                  if (dlab) begin
                     dlm_in = req.write_byte;
                  end else begin
                     ier_in = req.write_byte;
                  end
               end
               OFS_IIR_FCR: fcr_in = req.write_byte;
               OFS_LCR:     lcr_in = req.write_byte;
               OFS_MCR:     mcr_in = req.write_byte;
               OFS_LSR:     lsr_in = req.write_byte;
               OFS_MSR:     msr_in = req.write_byte;
               OFS_SCRATCH: scr_in = req.write_byte;
            endcase
         end
         OP_RECEIVE: begin
            // Overrun silently replaces the held character
            rxh_in             = req.rx_byte;
            lsr_in[LSR_DR_BIT] = 1'b1;
         end
         OP_UNUSED: begin
         end
      endcase

      // Interrupt sources on the updated registers
      rx_irq = lsr_in[LSR_DR_BIT] & ier_in[IER_RXDA_BIT];
      tx_irq = lsr_in[LSR_THRE_BIT] & ier_in[IER_THRE_BIT] & ~tx_rep_pre;
      want   = rx_irq | tx_irq;

      priority if (rx_irq) begin
         iir_in = IIR_RX_DATA;
      end else if (tx_irq) begin
         iir_in = IIR_TX_EMPTY;
      end else begin
         iir_in = IIR_NONE;
      end

      // Mark tx-empty reported only when it joins a rising request
      irq_active_in  = want;
      tx_reported_in = tx_rep_pre | (~irq_active_ff & want & tx_irq);
      rsp.irq_pulse  = ~irq_active_ff & want;
      rsp.irq_ident  = iir_in;

      // The unused opcode leaves everything as it is
      if (req.opcode == OP_UNUSED) begin
         iir_in         = iir_ff;
         irq_active_in  = irq_active_ff;
         tx_reported_in = tx_reported_ff;
         rsp.irq_pulse  = 1'b0;
         rsp.irq_ident  = iir_ff;
      end
   end

   // Commit the new register state when a request passes through
   always_ff @(posedge clock) begin
      if (reset) begin
         ier_ff         <= '0;
         fcr_ff         <= '0;
         lcr_ff         <= '0;
         mcr_ff         <= '0;
         lsr_ff         <= LSR_RESET;
         msr_ff         <= '0;
         scr_ff         <= '0;
         dll_ff         <= DLL_RESET;
         dlm_ff         <= DLM_RESET;
         iir_ff         <= IIR_NONE;
         rxh_ff         <= '0;
         irq_active_ff  <= 1'b0;
         tx_reported_ff <= 1'b0;
      end else if (step) begin
         ier_ff         <= ier_in;
         fcr_ff         <= fcr_in;
         lcr_ff         <= lcr_in;
         mcr_ff         <= mcr_in;
         lsr_ff         <= lsr_in;
         msr_ff         <= msr_in;
         scr_ff         <= scr_in;
         dll_ff         <= dll_in;
         dlm_ff         <= dlm_in;
         iir_ff         <= iir_in;
         rxh_ff         <= rxh_in;
         irq_active_ff  <= irq_active_in;
         tx_reported_ff <= tx_reported_in;
      end
   end

endmodule

// ===== src/uart_register_interrupt_model.sv =====
// 16550-style UART register file with interrupt identification.
// req_chan carries one request per handshake: a bus read, a bus write or a
// received character (opcode), with offset, write data and receive data.
// rsp_chan returns exactly one response per request, in order: read data,
// the transmitted byte when the data register was written, an interrupt
// pulse on each rise of the interrupt request, and the current IIR code.
// A request is captured in an input register; the register file applies it
// as it moves on and the response lands in the output register.
// One request is taken per cycle while rsp_chan does not stall; the register
// file update and the interrupt priority logic lie between the two registers.
// When rsp_chan stalls, the output register holds its response and the
// input register holds the next request; req_chan.ready drops only when
// both are occupied. Synchronous reset empties both registers and returns
// LSR to 0x60, the divisor latch to 0x0145, IIR to "none pending" and all
// other registers to zero.
module uart_register_interrupt_model import urim_pkg::*; (
   input logic       clock,
   input logic       reset,
   urim_req_if.sink  req_chan,
   urim_rsp_if.source rsp_chan
);

   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff;
   rsp_type result;
   logic    advance;
   logic    move;
   logic    take;

   // Stage control: the output register frees up when empty or drained
   assign advance        = ~out_valid_ff | rsp_chan.ready;
   assign move           = in_valid_ff & advance;
   assign req_chan.ready = ~in_valid_ff | advance;
   assign take           = req_chan.valid & req_chan.ready;

   assign in_valid_in  = take | (in_valid_ff & ~advance);
   assign out_valid_in = move | (out_valid_ff & ~rsp_chan.ready);

   urim_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .step  (move),
      .req   (in_ff),
      .rsp   (result)
   );

   // Hold valid flags; load payloads as requests advance
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (take) begin
         in_ff.opcode     <= req_chan.opcode;
         in_ff.reg_offset <= req_chan.reg_offset;
         in_ff.write_byte <= req_chan.write_byte;
         in_ff.rx_byte    <= req_chan.rx_byte;
      end
      if (move) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_byte = out_ff.read_byte;
   assign rsp_chan.tx_valid  = out_ff.tx_valid;
   assign rsp_chan.tx_byte   = out_ff.tx_byte;
   assign rsp_chan.irq_pulse = out_ff.irq_pulse;
   assign rsp_chan.irq_ident = out_ff.irq_ident;

endmodule

// ===== src/urim_checker.sv =====
`include "uart_register_interrupt_model_assert.svh"

module urim_checker import urim_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input byte_type  rsp_read_byte,
   input logic      rsp_tx_valid,
   input byte_type  rsp_tx_byte,
   input logic      rsp_irq_pulse,
   input ident_type rsp_irq_ident
);

   // A stalled response stays put
   `URIM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_byte) && $stable(rsp_tx_byte) && $stable(rsp_irq_ident))

   // IIR is always exactly one of none, tx-empty, rx-data
   `URIM_ASSERT_IMP(a_ident_code, clock, reset, rsp_valid, $onehot(rsp_irq_ident))

   // A rising request always names a pending source
   `URIM_ASSERT_IMP(a_pulse_ident, clock, reset, rsp_valid && rsp_irq_pulse, rsp_irq_ident != IIR_NONE)

   // No transmit byte without a transmit write
   `URIM_ASSERT_IMP(a_tx_zero, clock, reset, rsp_valid && !rsp_tx_valid, rsp_tx_byte == 8'd0)

   // Nothing is offered right after reset
   `URIM_ASSERT_IMP(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

endmodule

bind uart_register_interrupt_model urim_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_byte (rsp_chan.read_byte),
   .rsp_tx_valid  (rsp_chan.tx_valid),
   .rsp_tx_byte   (rsp_chan.tx_byte),
   .rsp_irq_pulse (rsp_chan.irq_pulse),
   .rsp_irq_ident (rsp_chan.irq_ident)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import urim_pkg::*;

   localparam int IDLE_LIMIT    = 1000;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_ITEMS  = 500;
   localparam int DRAIN_CYCLES  = 4;

   // Shadow of the UART registers: predicts one response per request
   class uart_reg_shadow;
      byte_type  ier, fcr, lcr, mcr, lsr, msr, scr, dll, dlm, rx_hold;
      ident_type iir;
      bit        irq_on;
      bit        tx_empty_marked;
      rsp_type   pending_responses[$];
      int        errors;

      function new();
         ier = '0;
         fcr = '0;
         lcr = '0;
         mcr = '0;
         lsr = LSR_RESET;
         msr = '0;
         scr = '0;
         dll = DLL_RESET;
         dlm = DLM_RESET;
         rx_hold = '0;
         iir = IIR_NONE;
         irq_on = 1'b0;
         tx_empty_marked = 1'b0;
         errors = 0;
      endfunction

      // Recompute IIR and report a rising interrupt request
      function bit refresh_interrupt();
         bit rx_irq;
         bit tx_irq;
         rx_irq = lsr[LSR_DR_BIT] && ier[IER_RXDA_BIT];
         tx_irq = lsr[LSR_THRE_BIT] && ier[IER_THRE_BIT] && !tx_empty_marked;
         if (rx_irq) begin
            iir = IIR_RX_DATA;
         end else if (tx_irq) begin
            iir = IIR_TX_EMPTY;
         end else begin
            iir = IIR_NONE;
         end
         if (!irq_on && (rx_irq || tx_irq)) begin
            irq_on = 1'b1;
            // tx-empty counts as reported only when it raises the request
            if (tx_irq) tx_empty_marked = 1'b1;
            return 1'b1;
         end
         if (irq_on && !(rx_irq || tx_irq)) irq_on = 1'b0;
         return 1'b0;
      endfunction

      // Apply one accepted request and queue the response it should give
      function void take_request(req_type r);
         rsp_type e;
         bit      dlab;
         e = '0;
         dlab = lcr[LCR_DLAB_BIT];
         case (r.opcode)
            OP_READ: begin
               case (r.reg_offset)
                  OFS_DATA: begin
                     if (dlab) begin
                        e.read_byte = dll;
                     end else begin
                        e.read_byte = rx_hold;
                        lsr[LSR_DR_BIT] = 1'b0;
                     end
                  end
                  OFS_IER:     e.read_byte = dlab ? dlm : ier;
                  OFS_IIR_FCR: e.read_byte = byte_type'(iir);
                  OFS_LCR:     e.read_byte = lcr;
                  OFS_MCR:     e.read_byte = mcr;
                  OFS_LSR:     e.read_byte = lsr;
                  OFS_MSR:     e.read_byte = msr;
                  default:     e.read_byte = scr;
               endcase
               e.irq_pulse = refresh_interrupt();
            end
            OP_WRITE: begin
               case (r.reg_offset)
                  OFS_DATA: begin
                     if (dlab) begin
                        dll = r.write_byte;
                     end else begin
                        e.tx_valid = 1'b1;
                        e.tx_byte = r.write_byte;
                        tx_empty_marked = 1'b0;
                     end
                  end
                  OFS_IER: begin
                     if (dlab) dlm = r.write_byte;
                     else ier = r.write_byte;
                  end
                  OFS_IIR_FCR: fcr = r.write_byte;
                  OFS_LCR:     lcr = r.write_byte;
                  OFS_MCR:     mcr = r.write_byte;
                  OFS_LSR:     lsr = r.write_byte;
                  OFS_MSR:     msr = r.write_byte;
                  default:     scr = r.write_byte;
               endcase
               e.irq_pulse = refresh_interrupt();
            end
            OP_RECEIVE: begin
               // an unread character is simply overwritten
               rx_hold = r.rx_byte;
               lsr[LSR_DR_BIT] = 1'b1;
               e.irq_pulse = refresh_interrupt();
            end
            default: ;
         endcase
         e.irq_ident = iir;
         pending_responses.push_back(e);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      // Compare one accepted response with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            return;
         end
         want = pending_responses.pop_front();
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
         compare_field("tx_byte", want.tx_byte, got.tx_byte);
         compare_field("irq_pulse", 8'(want.irq_pulse), 8'(got.irq_pulse));
         compare_field("irq_ident", 8'(want.irq_ident), 8'(got.irq_ident));
      endfunction
   endclass

   logic clock;
   logic reset;

   urim_req_if req_bus ();
   urim_rsp_if rsp_bus ();

   uart_register_interrupt_model u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   uart_reg_shadow regs = new();
   bit hold_rsp = 1'b0;
   int req_calm = 0;
   int rsp_calm = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Draw a random gap, with occasional runs of back-to-back traffic
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) calm = $urandom_range(10, 30);
      return $urandom_range(0, 8);
   endfunction

   function automatic req_type make_request(opcode_type op, offset_type ofs,
                                            byte_type wb, byte_type rb);
      req_type r;
      r.opcode = op;
      r.reg_offset = ofs;
      r.write_byte = wb;
      r.rx_byte = rb;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.reg_offset = offset_type'($urandom_range(0, 7));
      r.write_byte = byte_type'($urandom);
      r.rx_byte = byte_type'($urandom);
      if (pick < 35) r.opcode = OP_READ;
      else if (pick < 70) r.opcode = OP_WRITE;
      else if (pick < 95) r.opcode = OP_RECEIVE;
      else r.opcode = OP_UNUSED;
      // keep DLAB mostly clear so the data register stays reachable
      if (r.opcode == OP_WRITE && r.reg_offset == OFS_LCR && $urandom_range(0, 3) != 0)
         r.write_byte[LCR_DLAB_BIT] = 1'b0;
      // favor enabling both interrupt sources
      if (r.opcode == OP_WRITE && r.reg_offset == OFS_IER && $urandom_range(0, 1) == 0)
         r.write_byte[IER_THRE_BIT:IER_RXDA_BIT] = 2'b11;
      return r;
   endfunction

   // Offer one request after a random gap and hold it until taken
   task automatic send_request(input req_type r);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= r.opcode;
      req_bus.reg_offset <= r.reg_offset;
      req_bus.write_byte <= r.write_byte;
      req_bus.rx_byte    <= r.rx_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Note each accepted request
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         regs.take_request(make_request(req_bus.opcode, req_bus.reg_offset,
                                        req_bus.write_byte, req_bus.rx_byte));
   end

   // Check each accepted response
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.read_byte = rsp_bus.read_byte;
         got.tx_valid  = rsp_bus.tx_valid;
         got.tx_byte   = rsp_bus.tx_byte;
         got.irq_pulse = rsp_bus.irq_pulse;
         got.irq_ident = rsp_bus.irq_ident;
         regs.check_response(got);
      end
   end

   // Response side: random stalls, one long hold-off on request
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      wait (!reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // End the run when no request or response moves for too long
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle = 0;
         else
            idle++;
      end
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_READ;
      req_bus.reg_offset <= OFS_DATA;
      req_bus.write_byte <= '0;
      req_bus.rx_byte    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values, nothing received yet
      send_request(make_request(OP_READ, OFS_DATA, 8'h00, 8'h00));
      send_request(make_request(OP_READ, OFS_IIR_FCR, 8'h00, 8'h00));
      send_request(make_request(OP_READ, OFS_LSR, 8'h00, 8'h00));
      // Enable interrupts: tx-empty fires, then rx data takes priority
      send_request(make_request(OP_WRITE, OFS_IER, 8'hFF, 8'h00));
      send_request(make_request(OP_RECEIVE, OFS_DATA, 8'h00, 8'hFF));
      // Overrun replaces the held character
      send_request(make_request(OP_RECEIVE, OFS_SCRATCH, 8'hFF, 8'h00));
      send_request(make_request(OP_READ, OFS_DATA, 8'h00, 8'h00));
      // Transmit rearms tx-empty
      send_request(make_request(OP_WRITE, OFS_DATA, 8'hA5, 8'h00));
      // Divisor latch access
      send_request(make_request(OP_WRITE, OFS_LCR, 8'h80, 8'h00));
      send_request(make_request(OP_READ, OFS_DATA, 8'h00, 8'h00));
      send_request(make_request(OP_READ, OFS_IER, 8'h00, 8'h00));
      send_request(make_request(OP_WRITE, OFS_DATA, 8'hFF, 8'h00));
      send_request(make_request(OP_WRITE, OFS_IER, 8'h00, 8'h00));
      send_request(make_request(OP_READ, OFS_DATA, 8'h00, 8'h00));
      send_request(make_request(OP_READ, OFS_IER, 8'h00, 8'h00));
      send_request(make_request(OP_WRITE, OFS_LCR, 8'h03, 8'h00));
      // Line status writes replace data-ready and tx-empty
      send_request(make_request(OP_WRITE, OFS_LSR, 8'h01, 8'h00));
      send_request(make_request(OP_WRITE, OFS_LSR, 8'h00, 8'h00));
      send_request(make_request(OP_WRITE, OFS_MSR, 8'hFF, 8'h00));
      send_request(make_request(OP_WRITE, OFS_MCR, 8'hFF, 8'h00));
      send_request(make_request(OP_WRITE, OFS_IIR_FCR, 8'hFF, 8'h00));
      send_request(make_request(OP_WRITE, OFS_SCRATCH, 8'hFF, 8'h00));
      // Unused opcode leaves everything alone
      send_request(make_request(OP_UNUSED, OFS_SCRATCH, 8'hFF, 8'hFF));
      send_request(make_request(OP_WRITE, OFS_IER, 8'h00, 8'h00));
      send_request(make_request(OP_READ, OFS_SCRATCH, 8'h00, 8'h00));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // back up the pipeline once while requests keep coming
         if (i == RANDOM_ITEMS / 2) hold_rsp = 1'b1;
         send_request(random_request());
      end
      req_bus.valid <= 1'b0;

      // Drain outstanding responses
      while (regs.pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (regs.errors == 0 && regs.pending_responses.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/urim_pkg.sv
src/urim_if.sv
src/urim_regfile.sv
src/uart_register_interrupt_model.sv
src/urim_checker.sv
test/tb.sv
